### hw/rtl/ssc_pkg.sv
// Shared types and constants for the substring search and count block.
package ssc_pkg;

  localparam int NEEDLE_MAX_DEF = 16;
  localparam int MAX_LEN_DEF    = 65535;

  localparam int CP_W     = 21;
  localparam int SLOT_W   = 4;
  localparam int NLEN_W   = 5;
  localparam int START_W  = 16;
  localparam int IDX_W    = 16;
  localparam int CNT_W    = 17;
  localparam int HLEN_W   = 16;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 16;

  localparam logic FUNC_NEEDLE = 1'b0;
  localparam logic FUNC_HAY    = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_NEEDLE_LENGTH = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_SEARCH_START  = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic nd_we;
  } cell_ctl_t;

  typedef struct packed {
    logic last;
    logic acc;
  } tok_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   first_index;
    logic [CNT_W-1:0]   match_count;
    logic [HLEN_W-1:0]  haystack_length;
    logic               overflow;
  } res_t;

endpackage

### hw/rtl/substring_search_and_count.sv
// Top level of the streaming substring search and count block.
//
// Input words carry func, needle_slot, code_point and last. A word with func 0
// writes one needle character; a word with func 1 is a haystack character.
// The haystack ends at a character with last set, and one result word follows:
// found, first_index, match_count, haystack_length and overflow.
// cfg_we with cfg_index 0 sets needle_length, index 1 sets search_start; write
// them only while no haystack is in flight.
// Throughput: one input word per cycle while in_stall is low. The window compare
// is registered in the cell row as the character is taken; the greedy tally and
// the output register update from the s1 stage when it advances, which a stalled
// result can hold back after a last character.
// Reset clears the window, counters, config and valid flags; the needle store is not
// cleared and must be written before use.
// A stalled result holds; input keeps flowing until a second finished result
// would need the output register, then in_stall rises until it frees up.
module substring_search_and_count #(
  parameter int NEEDLE_MAX = ssc_pkg::NEEDLE_MAX_DEF,
  parameter int MAX_LEN    = ssc_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [ssc_pkg::SLOT_W-1:0]  in_needle_slot,
  input  logic [ssc_pkg::CP_W-1:0]    in_code_point,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [ssc_pkg::IDX_W-1:0]   out_first_index,
  output logic [ssc_pkg::CNT_W-1:0]   out_match_count,
  output logic [ssc_pkg::HLEN_W-1:0]  out_haystack_length,
  output logic                        out_overflow,
  input  logic                        cfg_we,
  input  logic [ssc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int LW = $clog2(NEEDLE_MAX + 1);
  localparam int NW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

  logic [ssc_pkg::NLEN_W-1:0]  nlen_r;
  logic [ssc_pkg::START_W-1:0] start_r;
  logic [LW-1:0]               ulen;

  logic                        in_acc, hay_acc, nd_acc, room, load, clear;
  logic [PW-1:0]               pos_r, pos_nxt, pos_step;

  logic                        s1_vld_r;
  ssc_pkg::tok_t               s1_tok_r;
  logic [PW-1:0]               s1_pos_r;
  logic                        blocked, adv, match;

  logic [ssc_pkg::CP_W-1:0]    win_q  [NEEDLE_MAX];
  logic [ssc_pkg::CP_W-1:0]    nd_q   [NEEDLE_MAX];
  logic [ssc_pkg::CP_W-1:0]    nd_cmp [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]       hit_q;
  ssc_pkg::res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlen_r  <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssc_pkg::CFG_NEEDLE_LENGTH: nlen_r  <= cfg_wdata[ssc_pkg::NLEN_W-1:0];
        ssc_pkg::CFG_SEARCH_START:  start_r <= cfg_wdata[ssc_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(nlen_r) > NEEDLE_MAX) begin
      ulen = LW'(NEEDLE_MAX);
    end else begin
      ulen = LW'(nlen_r);
    end
  end

  assign blocked  = s1_vld_r && s1_tok_r.last && out_valid && out_stall;
  assign in_stall = blocked;
  assign adv      = s1_vld_r && !blocked;

  assign in_acc   = in_valid && !in_stall;
  assign hay_acc  = in_acc && (in_func == ssc_pkg::FUNC_HAY);
  assign nd_acc   = in_acc && (in_func == ssc_pkg::FUNC_NEEDLE);
  assign room     = pos_r < PW'(MAX_LEN);
  assign load     = hay_acc && room;
  assign clear    = hay_acc && in_last;
  assign pos_step = load ? pos_r + 1'b1 : pos_r;

  always_comb begin
    pos_nxt = pos_r;
    if (clear) begin
      pos_nxt = '0;
    end else if (load) begin
      pos_nxt = pos_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (hay_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hay_acc) begin
      s1_tok_r.last <= in_last;
      s1_tok_r.acc  <= room;
      s1_pos_r      <= pos_step;
    end
  end

  for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
    localparam logic [LW-1:0] KV = LW'(k);
    ssc_pkg::cell_ctl_t       ctl;
    logic [ssc_pkg::CP_W-1:0] din;
    logic [LW-1:0]            sel;
    logic                     active;

    assign sel    = ulen - KV - LW'(1);
    assign active = KV < ulen;
    assign nd_cmp[k] = nd_q[sel[NW-1:0]];

    if (k == 0) begin : g_head
      assign din = in_code_point;
    end else begin : g_body
      assign din = win_q[k-1];
    end

    assign ctl.load  = load;
    assign ctl.clear = clear;
    assign ctl.nd_we = nd_acc && (32'(in_needle_slot) == k);

    ssc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .din    (din),
      .nd_din (in_code_point),
      .nd_cmp (nd_cmp[k]),
      .active (active),
      .win_q  (win_q[k]),
      .nd_q   (nd_q[k]),
      .hit_q  (hit_q[k])
    );
  end

  assign match = &hit_q;

  ssc_tally #(
    .PW (PW),
    .LW (LW)
  ) u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tok       (s1_tok_r),
    .pos       (s1_pos_r),
    .match     (match),
    .ulen      (ulen),
    .start     (start_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_found           = res.found;
  assign out_first_index     = res.first_index;
  assign out_match_count     = res.match_count;
  assign out_haystack_length = res.haystack_length;
  assign out_overflow        = res.overflow;

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_vld_r && s1_tok_r.last))
    else $error("result word without a final character");

  a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_LEN))
    else $error("position past maximum length");

  a_pos_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func == ssc_pkg::FUNC_HAY) && in_last) |=> (pos_r == '0))
    else $error("position not cleared after final character");

endmodule

### hw/rtl/ssc_cell.sv
// One window cell: a haystack character, a needle character and a compare flag.
module ssc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ssc_pkg::cell_ctl_t       ctl,
  input  logic [ssc_pkg::CP_W-1:0] din,
  input  logic [ssc_pkg::CP_W-1:0] nd_din,
  input  logic [ssc_pkg::CP_W-1:0] nd_cmp,
  input  logic                     active,
  output logic [ssc_pkg::CP_W-1:0] win_q,
  output logic [ssc_pkg::CP_W-1:0] nd_q,
  output logic                     hit_q
);

  logic [ssc_pkg::CP_W-1:0] win_r, win_nxt;
  logic [ssc_pkg::CP_W-1:0] nd_r;
  logic                     hit_r, hit_nxt;

  always_comb begin
    win_nxt = win_r;
    hit_nxt = hit_r;
    if (ctl.load) begin
      win_nxt = din;
      hit_nxt = !active || (din == nd_cmp);
    end
    if (ctl.clear) begin
      win_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      hit_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.nd_we) begin
      nd_r <= nd_din;
    end
  end

  assign win_q = win_r;
  assign nd_q  = nd_r;
  assign hit_q = hit_r;

endmodule

### hw/rtl/ssc_tally.sv
// Match tally: first match, greedy count, overflow and the result register.
module ssc_tally #(
  parameter int PW = 16,
  parameter int LW = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  ssc_pkg::tok_t               tok,
  input  logic [PW-1:0]               pos,
  input  logic                        match,
  input  logic [LW-1:0]               ulen,
  input  logic [ssc_pkg::START_W-1:0] start,
  input  logic                        out_stall,
  output logic                        out_valid,
  output ssc_pkg::res_t               res
);

  localparam int EW = PW + LW;
  localparam int CW = (EW > ssc_pkg::START_W) ? EW : ssc_pkg::START_W;

  logic                        seen_r, seen_nxt;
  logic [ssc_pkg::IDX_W-1:0]   first_r, first_nxt;
  logic [ssc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]               nas_r, nas_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        vld_r;
  ssc_pkg::res_t               res_r, res_nxt;
  logic                        hit;
  logic [EW-1:0]               s;

  always_comb begin
    s         = EW'(pos) - EW'(ulen);
    hit       = tok.acc && (ulen != '0) && (EW'(pos) >= EW'(ulen)) && match;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    nas_nxt   = nas_r;
    ovf_nxt   = ovf_r || !tok.acc;
    if (hit) begin
      if (!seen_r && (CW'(s) >= CW'(start))) begin
        seen_nxt  = 1'b1;
        first_nxt = ssc_pkg::IDX_W'(s);
      end
      if (s >= EW'(nas_r)) begin
        cnt_nxt = cnt_r + 1'b1;
        nas_nxt = pos;
      end
    end
    res_nxt.haystack_length = ssc_pkg::HLEN_W'(pos);
    res_nxt.overflow        = ovf_nxt;
    if (ulen == '0) begin
      res_nxt.found       = CW'(start) <= CW'(pos);
      res_nxt.first_index = res_nxt.found ? start : '0;
      res_nxt.match_count = ssc_pkg::CNT_W'(pos) + 1'b1;
    end else begin
      res_nxt.found       = seen_nxt;
      res_nxt.first_index = seen_nxt ? first_nxt : '0;
      res_nxt.match_count = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      first_r <= '0;
      cnt_r   <= '0;
      nas_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (adv) begin
      if (tok.last) begin
        seen_r  <= 1'b0;
        first_r <= '0;
        cnt_r   <= '0;
        nas_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        first_r <= first_nxt;
        cnt_r   <= cnt_nxt;
        nas_r   <= nas_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv && tok.last) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok.last) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign res       = res_r;

  a_found_first : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !res_r.found) |-> (res_r.first_index == '0))
    else $error("first_index set without a match");

endmodule
